[rtl/core/mhe_pkg.sv]
`default_nettype none

package mhe_pkg;

  // Action codes of an input item
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_EXTRACT = 1'b1;

  // Status codes of a result item
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Datapath operations issued by the controller
  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_CAPTURE = 4'd1;
  localparam logic [3:0] OP_LOAD    = 4'd2;
  localparam logic [3:0] OP_EMPTY   = 4'd3;
  localparam logic [3:0] OP_RD_ROOT = 4'd4;
  localparam logic [3:0] OP_RD_LAST = 4'd5;
  localparam logic [3:0] OP_TAKE    = 4'd6;
  localparam logic [3:0] OP_RD_L    = 4'd7;
  localparam logic [3:0] OP_RD_R    = 4'd8;
  localparam logic [3:0] OP_CMP     = 4'd9;
  localparam logic [3:0] OP_WR_CUR  = 4'd10;
  localparam logic [3:0] OP_PUSH    = 4'd11;

  typedef struct packed {
    logic               action;
    logic signed [31:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic        [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [3:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_load;
    logic empty;
    logic count_zero;
    logic no_left;
    logic swap;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/core/mhe_dp.sv]
`default_nettype none

module mhe_dp #(
  parameter int HEAP_DEPTH = 1024
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  mhe_pkg::in_item_t    in_data_i,
  input  wire                  out_stall_i,
  output logic                 out_valid_o,
  output mhe_pkg::out_item_t   out_data_o,
  input  mhe_pkg::dp_cmd_t     cmd_i,
  output mhe_pkg::dp_stat_t    stat_o
);

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int IW = AW + 2;

  // Heap storage, one write and one registered read per cycle
  logic [31:0] mem [HEAP_DEPTH];
  logic [31:0] rdata_q;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  logic [CW-1:0]       count_q;
  logic [AW-1:0]       pos_q;
  logic signed [31:0]  cur_q;
  logic signed [31:0]  lval_q;
  logic signed [31:0]  res_q;
  logic [1:0]          st_q;
  mhe_pkg::in_item_t   in_q;
  mhe_pkg::out_item_t  out_q;
  logic                out_valid_q;

  logic [IW-1:0] left_w;
  logic [IW-1:0] right_w;
  logic [IW-1:0] count_w;
  logic          full;
  logic          has_right;
  logic          take_l;
  logic          take_r;
  logic signed [31:0] rval;
  logic signed [31:0] best_val;

  // Child indices of the current slot
  assign left_w  = IW'({pos_q, 1'b1});
  assign right_w = IW'({pos_q, 1'b0}) + IW'(2);
  assign count_w = IW'(count_q);
  assign full    = (count_q == CW'(HEAP_DEPTH));
  assign has_right = (right_w < count_w);

  // Pick the larger child; left wins ties, swap only on strictly greater
  assign rval     = $signed(rdata_q);
  assign take_l   = (lval_q > cur_q);
  assign best_val = take_l ? lval_q : cur_q;
  assign take_r   = has_right && (rval > best_val);

  // Memory address and write control
  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = pos_q;
    wdata = cur_q;
    case (cmd_i.op)
      mhe_pkg::OP_LOAD: begin
        we    = !full;
        waddr = count_q[AW-1:0];
        wdata = in_q.load_value;
      end
      mhe_pkg::OP_RD_ROOT: raddr = '0;
      mhe_pkg::OP_RD_LAST: raddr = count_q[AW-1:0];
      mhe_pkg::OP_RD_L:    raddr = left_w[AW-1:0];
      mhe_pkg::OP_RD_R:    raddr = right_w[AW-1:0];
      mhe_pkg::OP_CMP: begin
        we    = 1'b1;
        wdata = take_r ? rval : (take_l ? lval_q : cur_q);
      end
      mhe_pkg::OP_WR_CUR:  we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Control state: entry count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Raise on push, drop once the item is taken
      if (cmd_i.op == mhe_pkg::OP_PUSH) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        mhe_pkg::OP_LOAD:    if (!full) count_q <= count_q + CW'(1);
        mhe_pkg::OP_RD_ROOT: count_q <= count_q - CW'(1);
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      mhe_pkg::OP_CAPTURE: in_q <= in_data_i;
      mhe_pkg::OP_LOAD: begin
        res_q <= '0;
        st_q  <= full ? mhe_pkg::ST_FULL : mhe_pkg::ST_OK;
      end
      mhe_pkg::OP_EMPTY: begin
        res_q <= '0;
        st_q  <= mhe_pkg::ST_EMPTY;
      end
      mhe_pkg::OP_RD_ROOT: st_q <= mhe_pkg::ST_OK;
      mhe_pkg::OP_RD_LAST: res_q <= $signed(rdata_q);
      mhe_pkg::OP_TAKE: begin
        cur_q <= $signed(rdata_q);
        pos_q <= '0;
      end
      mhe_pkg::OP_RD_R: lval_q <= $signed(rdata_q);
      mhe_pkg::OP_CMP: begin
        if (take_r) begin
          pos_q <= right_w[AW-1:0];
        end else if (take_l) begin
          pos_q <= left_w[AW-1:0];
        end
      end
      mhe_pkg::OP_PUSH: begin
        out_q.result_value <= res_q;
        out_q.status       <= st_q;
      end
      default: ;
    endcase
  end

  assign stat_o.is_load    = (in_q.action == mhe_pkg::ACT_LOAD);
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.no_left    = (left_w >= count_w);
  assign stat_o.swap       = take_l || take_r;
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/core/mhe_ctrl.sv]
`default_nettype none

module mhe_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  mhe_pkg::dp_stat_t  stat_i,
  output mhe_pkg::dp_cmd_t   cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_RD_LAST = 4'd2;
  localparam logic [3:0] S_TAKE    = 4'd3;
  localparam logic [3:0] S_RD_L    = 4'd4;
  localparam logic [3:0] S_RD_R    = 4'd5;
  localparam logic [3:0] S_CMP     = 4'd6;
  localparam logic [3:0] S_FIN     = 4'd7;

  logic [3:0] state_q;
  logic [3:0] state_d;

  // Sequence one item at a time
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = mhe_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = mhe_pkg::OP_CAPTURE;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.is_load) begin
          cmd_o.op = mhe_pkg::OP_LOAD;
          state_d  = S_FIN;
        end else if (stat_i.empty) begin
          cmd_o.op = mhe_pkg::OP_EMPTY;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = mhe_pkg::OP_RD_ROOT;
          state_d  = S_RD_LAST;
        end
      end
      S_RD_LAST: begin
        cmd_o.op = mhe_pkg::OP_RD_LAST;
        state_d  = stat_i.count_zero ? S_FIN : S_TAKE;
      end
      S_TAKE: begin
        cmd_o.op = mhe_pkg::OP_TAKE;
        state_d  = S_RD_L;
      end
      S_RD_L: begin
        if (stat_i.no_left) begin
          cmd_o.op = mhe_pkg::OP_WR_CUR;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = mhe_pkg::OP_RD_L;
          state_d  = S_RD_R;
        end
      end
      S_RD_R: begin
        cmd_o.op = mhe_pkg::OP_RD_R;
        state_d  = S_CMP;
      end
      S_CMP: begin
        cmd_o.op = mhe_pkg::OP_CMP;
        state_d  = stat_i.swap ? S_RD_L : S_FIN;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.op = mhe_pkg::OP_PUSH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

[rtl/core/max_heap_extract_top.sv]
// Sequence: a load or an empty extract is captured, dispatched, then pushed; an
// extract reads the root and the last entry, takes the last one and, per level
// it descends (at most 9 at 1024 entries), reads both children and compares,
// down to a leaf or until a compare stops it; a lone entry is pushed after the reads.
// Throughput: one item at a time; the next is accepted in the cycle after the push,
// and a stalled earlier result delays the push.
// Reset: asynchronous active low; clears the entry count, output valid and state.
`default_nettype none

module max_heap_extract_top #(
  parameter int HEAP_DEPTH = 1024
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  mhe_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output mhe_pkg::out_item_t  out_data_o
);

  mhe_pkg::dp_cmd_t  cmd;
  mhe_pkg::dp_stat_t stat;

  mhe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mhe_dp #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

`default_nettype wire

[rtl/core/mhe_checker.sv]
`default_nettype none

module mhe_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_stall_o,
  input wire                out_valid_o,
  input wire                out_stall_i,
  input mhe_pkg::out_item_t out_data_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled item dropped or changed");

  // Stall input while an accepted item is in work
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while item in work");

  // Never raise a result right after accepting an item
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result too early");

  // Return zero with any non-ok status
  a_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != mhe_pkg::ST_OK) |->
      out_data_o.result_value == 32'sd0)
    else $error("nonzero value with error status");

  // Emit only defined status codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == mhe_pkg::ST_OK) ||
      (out_data_o.status == mhe_pkg::ST_EMPTY) ||
      (out_data_o.status == mhe_pkg::ST_FULL))
    else $error("undefined status code");

endmodule

bind max_heap_extract_top mhe_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
